// ===== src/sna_pkg.sv =====
// Shared types and constants for the seconds/nanoseconds duration ALU.
// Used by every module of the block; depends on nothing else.
package sna_pkg;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_LESS = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4
   } sna_cmd_type;

   localparam logic signed [31:0] NS_PER_S   = 32'sd1000000000;
   localparam logic        [31:0] NS_PER_S_U = 32'd1000000000;
   localparam logic signed [63:0] SEC_MIN    = {1'b1, 63'd0};
   localparam logic signed [63:0] SEC_MAX    = {1'b0, {63{1'b1}}};

   // one restoring-division cell per quotient bit
   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [63:0] a_seconds;
      logic signed [31:0] a_nanoseconds;
      logic signed [63:0] b_seconds;
      logic signed [31:0] b_nanoseconds;
      logic signed [31:0] factor;
   } sna_req_type;

   typedef struct packed {
      logic               ok;
      logic signed [63:0] res_seconds;
      logic        [29:0] res_nanoseconds;
      logic               is_less;
   } sna_rsp_type;

   // sideband that travels with every operation through the cell rows
   typedef struct packed {
      logic        [2:0]  cmd;
      logic               pre_ok;
      logic               less;
      logic               neg_q;
      logic               neg_r;
      logic               f_neg;
      logic        [29:0] a_ns;
      logic signed [63:0] acc_s;
      logic signed [31:0] acc_n;
   } sna_side_type;

   typedef struct packed {
      logic [31:0]  rem;
      logic [63:0]  num;
      logic [31:0]  dvs;
      sna_side_type side;
   } sna_div_type;

endpackage

// ===== src/seconds_nanoseconds_duration_alu.sv =====
// Duration ALU on signed 64-bit seconds plus nanoseconds: add, subtract,
// less-than, multiply and divide by a signed 32-bit factor. One transfer is
// taken every cycle unless a result is held by rsp_stall; each result passes through
// six front stages, a row of 64 division cells, two middle stages, a second
// row of 64 cells and two output stages. The two division rows (one quotient
// bit per cell) set the depth. When a result is held by rsp_stall the whole
// pipeline holds and req_stall is raised in the same cycle.
module seconds_nanoseconds_duration_alu (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sna_pkg::sna_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sna_pkg::sna_rsp_type rsp_data
);
   import sna_pkg::*;

   logic                 adv;
   logic [DIV_STEPS:0]   c1_valid, c2_valid;
   sna_div_type          c1_data [0:DIV_STEPS];
   sna_div_type          c2_data [0:DIV_STEPS];

   // advance every stage unless a finished result is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   sna_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .out_valid (c1_valid[0]),
      .out_data  (c1_data[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_row1
      sna_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c1_valid[i]),
         .in_data   (c1_data[i]),
         .out_valid (c1_valid[i+1]),
         .out_data  (c1_data[i+1])
      );
   end

   sna_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c1_valid[DIV_STEPS]),
      .in_data   (c1_data[DIV_STEPS]),
      .out_valid (c2_valid[0]),
      .out_data  (c2_data[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_row2
      sna_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c2_valid[i]),
         .in_data   (c2_data[i]),
         .out_valid (c2_valid[i+1]),
         .out_data  (c2_data[i+1])
      );
   end

   sna_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c2_valid[DIV_STEPS]),
      .in_data   (c2_data[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |->
         (rsp_data.res_seconds == 64'sd0) && (rsp_data.res_nanoseconds == 30'd0))
      else $error("failed result carries a non-zero duration");

   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok |-> ({2'b0, rsp_data.res_nanoseconds} < NS_PER_S_U))
      else $error("nanoseconds out of range");

   a_less_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_less |->
         rsp_data.ok && (rsp_data.res_seconds == 64'sd0))
      else $error("less-than flag on an invalid or duration result");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input held while output is free");
`endif

endmodule

// ===== src/sna_front.sv =====
// Front stages: operand checks, add/subtract/compare and the 64x32 checked product.
// Feeds the first division row. Depends on sna_pkg.
module sna_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                req_valid,
   input  sna_pkg::sna_req_type req_data,
   output logic                out_valid,
   output sna_pkg::sna_div_type out_data
);
   import sna_pkg::*;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] an;
      logic        [63:0] ua;
      logic        [31:0] um;
      logic signed [63:0] p;
      logic signed [63:0] a_s;
      logic signed [63:0] ys;
      logic signed [31:0] yn;
      logic               av;
      logic               bv;
      logic               less;
      logic               a_neg;
      logic               f_neg;
      logic               div_bad;
   } st2_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] an;
      logic        [63:0] ua;
      logic        [31:0] um;
      logic        [63:0] lo;
      logic        [63:0] pmag;
      logic               p_neg;
      logic signed [63:0] s_add;
      logic               add_ok;
      logic signed [31:0] n_add;
      logic               av;
      logic               bv;
      logic               less;
      logic               a_neg;
      logic               f_neg;
      logic               div_bad;
   } st3_type;

   typedef struct packed {
      st3_type     base;
      logic [63:0] hi;
   } st4_type;

   typedef struct packed {
      st3_type     base;
      logic [63:0] tot;
      logic        mul_ovf;
   } st5_type;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   sna_req_type s1_ff;
   st2_type     s2_ff, s2_in;
   st3_type     s3_ff, s3_in;
   st4_type     s4_ff, s4_in;
   st5_type     s5_ff, s5_in;
   logic        s6_valid_ff;
   sna_div_type s6_ff, s6_in;

   logic        [64:0] tot_sum;
   logic               mneg;
   logic               lim_ovf;
   logic signed [63:0] rs_mul;

   // stage 2: magnitudes, nanosecond product, compare, subtrahend negation
   always_comb begin
      s2_in.cmd     = s1_ff.cmd;
      s2_in.an      = s1_ff.a_nanoseconds;
      s2_in.a_s     = s1_ff.a_seconds;
      s2_in.a_neg   = s1_ff.a_seconds[63];
      s2_in.f_neg   = s1_ff.factor[31];
      s2_in.av      = (s1_ff.a_nanoseconds >= 32'sd0) && (s1_ff.a_nanoseconds < NS_PER_S);
      s2_in.bv      = (s1_ff.b_nanoseconds >= 32'sd0) && (s1_ff.b_nanoseconds < NS_PER_S);
      s2_in.ua      = s1_ff.a_seconds[63] ? 64'd0 - $unsigned(s1_ff.a_seconds)
                                          : $unsigned(s1_ff.a_seconds);
      s2_in.um      = s1_ff.factor[31] ? 32'd0 - $unsigned(s1_ff.factor)
                                       : $unsigned(s1_ff.factor);
      s2_in.p       = 64'(s1_ff.a_nanoseconds) * 64'(s1_ff.factor);
      s2_in.less    = (s1_ff.a_seconds < s1_ff.b_seconds) ||
                      ((s1_ff.a_seconds == s1_ff.b_seconds) &&
                       (s1_ff.a_nanoseconds < s1_ff.b_nanoseconds));
      s2_in.div_bad = (s1_ff.factor == 32'sd0) ||
                      ((s1_ff.a_seconds == SEC_MIN) && (s1_ff.factor == -32'sd1));
      if (s1_ff.cmd == CMD_SUB) begin
         // negate b as whole seconds plus a non-negative nanosecond part
         if (!s1_ff.b_seconds[63] && (s1_ff.b_nanoseconds == 32'sd0)) begin
            s2_in.ys = -s1_ff.b_seconds;
            s2_in.yn = 32'sd0;
         end else begin
            s2_in.ys = ~s1_ff.b_seconds;
            s2_in.yn = NS_PER_S - s1_ff.b_nanoseconds;
         end
      end else begin
         s2_in.ys = s1_ff.b_seconds;
         s2_in.yn = s1_ff.b_nanoseconds;
      end
   end

   // stage 3: low partial product, checked seconds sum
   always_comb begin
      s3_in.cmd     = s2_ff.cmd;
      s3_in.an      = s2_ff.an;
      s3_in.ua      = s2_ff.ua;
      s3_in.um      = s2_ff.um;
      s3_in.lo      = {32'd0, s2_ff.ua[31:0]} * {32'd0, s2_ff.um};
      s3_in.p_neg   = s2_ff.p[63];
      s3_in.pmag    = s2_ff.p[63] ? 64'd0 - $unsigned(s2_ff.p) : $unsigned(s2_ff.p);
      s3_in.s_add   = s2_ff.a_s + s2_ff.ys;
      s3_in.add_ok  = !((s2_ff.a_s[63] == s2_ff.ys[63]) &&
                        (s3_in.s_add[63] != s2_ff.a_s[63]));
      s3_in.n_add   = s2_ff.an + s2_ff.yn;
      s3_in.av      = s2_ff.av;
      s3_in.bv      = s2_ff.bv;
      s3_in.less    = s2_ff.less;
      s3_in.a_neg   = s2_ff.a_neg;
      s3_in.f_neg   = s2_ff.f_neg;
      s3_in.div_bad = s2_ff.div_bad;
   end

   // stage 4: high partial product
   always_comb begin
      s4_in.base = s3_ff;
      s4_in.hi   = {32'd0, s3_ff.ua[63:32]} * {32'd0, s3_ff.um};
   end

   // stage 5: combine partial products
   always_comb begin
      tot_sum       = {1'b0, s4_ff.hi[31:0], 32'd0} + {1'b0, s4_ff.base.lo};
      s5_in.base    = s4_ff.base;
      s5_in.tot     = tot_sum[63:0];
      s5_in.mul_ovf = (|s4_ff.hi[63:32]) | tot_sum[64];
   end

   // stage 6: range check and sign of the product, load the division row
   always_comb begin
      mneg    = s5_ff.base.a_neg ^ s5_ff.base.f_neg;
      lim_ovf = s5_ff.tot[63] && (!mneg || (s5_ff.tot[62:0] != 63'd0));
      rs_mul  = mneg ? $signed(64'd0 - s5_ff.tot) : $signed(s5_ff.tot);

      s6_in.rem          = 32'd0;
      s6_in.num          = 64'd0;
      s6_in.dvs          = NS_PER_S_U;
      s6_in.side.cmd     = s5_ff.base.cmd;
      s6_in.side.pre_ok  = 1'b0;
      s6_in.side.less    = 1'b0;
      s6_in.side.neg_q   = 1'b0;
      s6_in.side.neg_r   = 1'b0;
      s6_in.side.f_neg   = s5_ff.base.f_neg;
      s6_in.side.a_ns    = s5_ff.base.an[29:0];
      s6_in.side.acc_s   = 64'sd0;
      s6_in.side.acc_n   = 32'sd0;
      case (s5_ff.base.cmd)
         CMD_ADD, CMD_SUB: begin
            s6_in.side.pre_ok = s5_ff.base.av && s5_ff.base.bv && s5_ff.base.add_ok;
            s6_in.side.acc_s  = s5_ff.base.s_add;
            s6_in.side.acc_n  = s5_ff.base.n_add;
         end
         CMD_LESS: begin
            s6_in.side.pre_ok = s5_ff.base.av && s5_ff.base.bv;
            s6_in.side.less   = s5_ff.base.av && s5_ff.base.bv && s5_ff.base.less;
         end
         CMD_MUL: begin
            // split the nanosecond product into carry seconds and remainder
            s6_in.side.pre_ok = s5_ff.base.av && !s5_ff.mul_ovf && !lim_ovf;
            s6_in.side.acc_s  = rs_mul;
            s6_in.side.neg_q  = s5_ff.base.p_neg;
            s6_in.side.neg_r  = s5_ff.base.p_neg;
            s6_in.num         = s5_ff.base.pmag;
         end
         CMD_DIV: begin
            s6_in.side.pre_ok = s5_ff.base.av && !s5_ff.base.div_bad;
            s6_in.side.neg_q  = s5_ff.base.a_neg ^ s5_ff.base.f_neg;
            s6_in.side.neg_r  = s5_ff.base.a_neg;
            s6_in.num         = s5_ff.base.ua;
            s6_in.dvs         = s5_ff.base.um;
         end
         default: begin
            s6_in.side.pre_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
      if (adv) begin
         s1_ff <= req_data;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_data  = s6_ff;

endmodule

// ===== src/sna_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands on the sideband.
// Depends on sna_pkg.
module sna_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sna_pkg::sna_div_type in_data,
   output logic                out_valid,
   output sna_pkg::sna_div_type out_data
);
   import sna_pkg::*;

   logic        valid_ff;
   sna_div_type data_ff, data_in;
   logic [33:0] trial;
   logic        qbit;

   always_comb begin
      trial        = {1'b0, in_data.rem, in_data.num[63]} - {2'b0, in_data.dvs};
      qbit         = !trial[33];
      data_in      = in_data;
      data_in.rem  = qbit ? trial[31:0] : {in_data.rem[30:0], in_data.num[63]};
      data_in.num  = {in_data.num[62:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/sna_mid.sv =====
// Stages between the two division rows: sign the first quotient, finish the
// multiply carry and form the nanosecond dividend for divide. Depends on sna_pkg.
module sna_mid (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sna_pkg::sna_div_type in_data,
   output logic                out_valid,
   output sna_pkg::sna_div_type out_data
);
   import sna_pkg::*;

   typedef struct packed {
      sna_side_type       side;
      logic        [31:0] dvs;
      logic signed [63:0] q_s;
      logic signed [31:0] r_s;
      logic        [63:0] prod;
   } m1_type;

   logic        m1_valid_ff, m2_valid_ff;
   m1_type      m1_ff, m1_in;
   sna_div_type m2_ff, m2_in;
   logic signed [63:0] sum;
   logic        [63:0] an_ext;

   always_comb begin
      m1_in.side = in_data.side;
      m1_in.dvs  = in_data.dvs;
      m1_in.q_s  = in_data.side.neg_q ? $signed(64'd0 - in_data.num) : $signed(in_data.num);
      m1_in.r_s  = in_data.side.neg_r ? -$signed(in_data.rem) : $signed(in_data.rem);
      m1_in.prod = {32'd0, in_data.rem} * {32'd0, NS_PER_S_U};
   end

   always_comb begin
      sum    = m1_ff.side.acc_s + m1_ff.q_s;
      an_ext = {34'd0, m1_ff.side.a_ns};
      m2_in      = '0;
      m2_in.side = m1_ff.side;
      m2_in.dvs  = m1_ff.dvs;
      case (m1_ff.side.cmd)
         CMD_MUL: begin
            m2_in.side.acc_s  = sum;
            m2_in.side.acc_n  = m1_ff.r_s;
            m2_in.side.pre_ok = m1_ff.side.pre_ok &&
                                !((m1_ff.side.acc_s[63] == m1_ff.q_s[63]) &&
                                  (sum[63] != m1_ff.side.acc_s[63]));
         end
         CMD_DIV: begin
            // dividend is nanoseconds plus the signed remainder in nanoseconds
            m2_in.side.acc_s = m1_ff.q_s;
            if (!m1_ff.side.neg_r) begin
               m2_in.num        = m1_ff.prod + an_ext;
               m2_in.side.neg_q = m1_ff.side.f_neg;
            end else if (m1_ff.prod == 64'd0) begin
               m2_in.num        = an_ext;
               m2_in.side.neg_q = m1_ff.side.f_neg;
            end else begin
               m2_in.num        = m1_ff.prod - an_ext;
               m2_in.side.neg_q = !m1_ff.side.f_neg;
            end
         end
         default: begin
            m2_in.num = 64'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
      end
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   assign out_valid = m2_valid_ff;
   assign out_data  = m2_ff;

endmodule

// ===== src/sna_back.sv =====
// Final stages: sign the divide nanoseconds, normalize, drive the result register.
// Depends on sna_pkg.
module sna_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sna_pkg::sna_div_type in_data,
   output logic                out_valid,
   output sna_pkg::sna_rsp_type out_data
);
   import sna_pkg::*;

   logic         b1_valid_ff, rsp_valid_ff;
   sna_side_type b1_ff, b1_in;
   sna_rsp_type  rsp_ff, rsp_in;
   logic signed [63:0] s_o;
   logic signed [31:0] n_o;
   logic               nok;
   logic               ok;

   always_comb begin
      b1_in = in_data.side;
      if (in_data.side.cmd == CMD_DIV) begin
         b1_in.acc_n = in_data.side.neg_q ? -$signed(in_data.num[31:0])
                                          : $signed(in_data.num[31:0]);
      end
   end

   always_comb begin
      s_o = b1_ff.acc_s;
      n_o = b1_ff.acc_n;
      nok = 1'b1;
      if (b1_ff.acc_n < 32'sd0) begin
         nok = b1_ff.acc_s != SEC_MIN;
         s_o = b1_ff.acc_s - 64'sd1;
         n_o = b1_ff.acc_n + NS_PER_S;
      end else if (b1_ff.acc_n >= NS_PER_S) begin
         nok = b1_ff.acc_s != SEC_MAX;
         s_o = b1_ff.acc_s + 64'sd1;
         n_o = b1_ff.acc_n - NS_PER_S;
      end
      ok = b1_ff.pre_ok && nok;
      rsp_in.ok      = ok;
      rsp_in.is_less = b1_ff.less;
      if (ok && (b1_ff.cmd != CMD_LESS)) begin
         rsp_in.res_seconds     = s_o;
         rsp_in.res_nanoseconds = n_o[29:0];
      end else begin
         rsp_in.res_seconds     = 64'sd0;
         rsp_in.res_nanoseconds = 30'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= in_valid;
         rsp_valid_ff <= b1_valid_ff;
      end
      if (adv) begin
         b1_ff  <= b1_in;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule
